@@ hdl/bch_pkg.sv @@
package bch_pkg;

   // Code geometry.
   localparam int CODE_BITS   = 26;
   localparam int DATA_BITS   = 16;
   localparam int PARITY_BITS = 10;
   localparam int GEN_BITS    = 11;
   localparam int STEP_BITS   = $clog2(DATA_BITS);

   typedef logic [CODE_BITS-1:0]   code_type;
   typedef logic [PARITY_BITS-1:0] syn_type;
   typedef logic [GEN_BITS-1:0]    gen_type;
   typedef logic [STEP_BITS-1:0]   step_type;

   // One syndrome pattern per error position, in search order (word bit 25 first).
   typedef logic [CODE_BITS-1:0][PARITY_BITS-1:0] pat_table_type;

   localparam gen_type  GEN_RESET = GEN_BITS'(1465);
   localparam code_type TOP_BIT   = code_type'(1) << (CODE_BITS - 1);

   typedef enum logic {
      CMD_ENCODE  = 1'b0,
      CMD_CORRECT = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_NONE = 2'd0,
      ST_ONE  = 2'd1,
      ST_TWO  = 2'd2,
      ST_FAIL = 2'd3
   } status_type;

   // One step of the long division: fold in the aligned generator when the
   // top bit is set, then shift left, dropping the bit that leaves the word.
   function automatic code_type div_step(code_type r, gen_type gen);
      code_type aligned;
      code_type t;
      aligned = {gen, {(CODE_BITS - GEN_BITS){1'b0}}};
      t       = r[CODE_BITS-1] ? (r ^ aligned) : r;
      return {t[CODE_BITS-2:0], 1'b0};
   endfunction

endpackage

@@ hdl/bch_pattern_table.sv @@
module bch_pattern_table (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  bch_pkg::gen_type      csr_data,
   output bch_pkg::pat_table_type tab,
   output logic                  busy
);
   import bch_pkg::*;

   logic     busy_ff, busy_in;
   step_type count_ff, count_in;
   code_type reg_ff, reg_in;
   gen_type  gen_ff;
   logic [DATA_BITS-1:0][PARITY_BITS-1:0] data_tab_ff;

   // Generator register; a write restarts the table build.
   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff <= GEN_RESET;
      end else if (csr_valid) begin
         gen_ff <= csr_data;
      end
   end

   // Repeated division steps from the top bit give the data-bit patterns,
   // lowest data position first; one entry is finished each cycle.
   always_comb begin
      reg_in   = div_step(reg_ff, gen_ff);
      count_in = count_ff + step_type'(1);
      busy_in  = busy_ff && (count_ff != step_type'(DATA_BITS - 1));
   end

   always_ff @(posedge clock) begin
      if (reset || csr_valid) begin
         busy_ff  <= 1'b1;
         count_ff <= '0;
         reg_ff   <= TOP_BIT;
      end else if (busy_ff) begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
         reg_ff   <= reg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         data_tab_ff[step_type'(DATA_BITS - 1) - count_ff] <=
            reg_in[CODE_BITS-1 -: PARITY_BITS];
      end
   end

   // Parity positions have their own bit as the pattern.
   always_comb begin
      for (int i = 0; i < DATA_BITS; i++) begin
         tab[i] = data_tab_ff[i];
      end
      for (int i = DATA_BITS; i < CODE_BITS; i++) begin
         tab[i] = syn_type'(1) << (CODE_BITS - 1 - i);
      end
   end

   assign busy = busy_ff;

   a_reset_builds: assert property (@(posedge clock) reset |=> busy_ff)
      else $error("table build did not start after reset");
   a_write_restarts: assert property (@(posedge clock)
      csr_valid |=> busy_ff && (count_ff == '0))
      else $error("generator write did not restart the table build");
   a_build_ends: assert property (@(posedge clock)
      !reset && !csr_valid && busy_ff && (count_ff == step_type'(DATA_BITS - 1))
      |=> !busy_ff)
      else $error("table build did not finish after the last step");

endmodule

@@ hdl/bch_26_16_encoder_corrector.sv @@
// Encoder and single/double-error corrector for a shortened (26,16) cyclic
// code with a writable degree-10 generator.
// Input channel req_*: req_tuser selects encode (0) or check-and-correct (1);
// req_tdata carries the word. Result channel rsp_*: corrected or encoded
// codeword, syndrome and status. Configuration channel csr_*: writes the
// 11-bit generator polynomial; it is always ready.
// Path: an accepted item passes through the capture, syndrome, compare and
// first-match registers, then the output register that shows its result.
// Throughput: one item per cycle while the receiver takes results and no
// table build runs; each register stage does one slice of the work: capture,
// syndrome XOR network, pattern compares, per-row first-match pick, final
// selection.
// After reset, and after every generator write, the data-bit syndrome table
// is rebuilt by one division step per cycle, and req_tready stays low until
// the build is done. The generator resets to 0x5B9.
// When the receiver stalls, the whole pipeline holds and req_tready drops as
// soon as the output register is full and not taken; nothing is dropped.
module bch_26_16_encoder_corrector (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [31:0]                 req_tdata,  // [25:0] word, [31:26] zero
   input  logic                        req_tuser,  // [0] command
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [39:0]                 rsp_tdata,  // [25:0] codeword, [35:26] syndrome,
                                                   // [37:36] status, [39:38] zero
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [bch_pkg::GEN_BITS-1:0] csr_data   // generator polynomial
);
   import bch_pkg::*;

   pat_table_type tab;
   logic          tbl_busy;
   logic          enable;

   bch_pattern_table u_table (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .tab       (tab),
      .busy      (tbl_busy)
   );

   assign csr_ready  = 1'b1;
   assign enable     = !rsp_tvalid || rsp_tready;
   assign req_tready = enable && !tbl_busy;

   // Stage 1: capture the item; encode places the data above the parity bits.
   logic     s1_valid_ff;
   cmd_type  s1_cmd_ff;
   code_type s1_word_ff, s1_word_in;

   always_comb begin
      if (cmd_type'(req_tuser) == CMD_ENCODE) begin
         s1_word_in = {req_tdata[DATA_BITS-1:0], {PARITY_BITS{1'b0}}};
      end else begin
         s1_word_in = req_tdata[CODE_BITS-1:0];
      end
   end

   // Stage 2: syndrome as the XOR of the patterns of all set bits.
   logic     s2_valid_ff;
   cmd_type  s2_cmd_ff;
   code_type s2_word_ff;
   syn_type  s2_syn_ff, s2_syn_in;
   logic [PARITY_BITS-1:0][CODE_BITS-1:0] col;

   always_comb begin
      for (int b = 0; b < PARITY_BITS; b++) begin
         for (int i = 0; i < CODE_BITS; i++) begin
            col[b][CODE_BITS-1-i] = tab[i][b];
         end
         s2_syn_in[b] = ^(s1_word_ff & col[b]);
      end
   end

   // Stage 3: compare the syndrome with every single and pair pattern.
   logic     s3_valid_ff;
   cmd_type  s3_cmd_ff;
   code_type s3_word_ff;
   syn_type  s3_syn_ff;
   logic [CODE_BITS-1:0] s3_single_ff, s3_single_in;
   logic [CODE_BITS-1:0][CODE_BITS-1:0] s3_pair_ff, s3_pair_in;

   always_comb begin
      for (int i = 0; i < CODE_BITS; i++) begin
         s3_single_in[i] = (tab[i] == s2_syn_ff);
         for (int j = 0; j < CODE_BITS; j++) begin
            s3_pair_in[i][j] = (j > i) && ((tab[i] ^ tab[j]) == s2_syn_ff);
         end
      end
   end

   // Stage 4: keep only the first match in each row and among singles.
   logic     s4_valid_ff;
   cmd_type  s4_cmd_ff;
   code_type s4_word_ff;
   syn_type  s4_syn_ff;
   logic [CODE_BITS-1:0] s4_single_ff, s4_single_in;
   logic [CODE_BITS-1:0] s4_row_hit_ff, s4_row_hit_in;
   logic [CODE_BITS-1:0][CODE_BITS-1:0] s4_row_first_ff, s4_row_first_in;

   always_comb begin
      s4_single_in = s3_single_ff & (~s3_single_ff + code_type'(1));
      for (int i = 0; i < CODE_BITS; i++) begin
         s4_row_hit_in[i]   = |s3_pair_ff[i];
         s4_row_first_in[i] = s3_pair_ff[i] & (~s3_pair_ff[i] + code_type'(1));
      end
   end

   // Output stage: pick the branch and build the encoded or corrected word.
   logic       out_valid_ff;
   code_type   out_code_ff, out_code_in;
   syn_type    out_syn_ff;
   status_type out_status_ff, out_status_in;
   logic [CODE_BITS-1:0] row_sel;
   logic [CODE_BITS-1:0] pair_ord;
   code_type             single_bits, pair_bits;

   always_comb begin
      row_sel  = s4_row_hit_ff & (~s4_row_hit_ff + code_type'(1));
      pair_ord = row_sel;
      for (int i = 0; i < CODE_BITS; i++) begin
         pair_ord = pair_ord | (row_sel[i] ? s4_row_first_ff[i] : '0);
      end
      for (int i = 0; i < CODE_BITS; i++) begin
         single_bits[CODE_BITS-1-i] = s4_single_ff[i];
         pair_bits[CODE_BITS-1-i]   = pair_ord[i];
      end
   end

   always_comb begin
      out_code_in   = s4_word_ff;
      out_status_in = ST_NONE;
      if (s4_cmd_ff == CMD_ENCODE) begin
         out_code_in = s4_word_ff | {{DATA_BITS{1'b0}}, s4_syn_ff};
      end else if (s4_syn_ff == '0) begin
         out_status_in = ST_NONE;
      end else if (|s4_single_ff) begin
         out_code_in   = s4_word_ff ^ single_bits;
         out_status_in = ST_ONE;
      end else if (|s4_row_hit_ff) begin
         out_code_in   = s4_word_ff ^ pair_bits;
         out_status_in = ST_TWO;
      end else begin
         out_status_in = ST_FAIL;
      end
   end

   // Valid bits of all stages; the pipeline moves as one on enable.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         s1_valid_ff  <= req_tvalid && !tbl_busy;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         out_valid_ff <= s4_valid_ff;
      end
   end

   // Payload registers of all stages.
   always_ff @(posedge clock) begin
      if (enable) begin
         s1_cmd_ff       <= cmd_type'(req_tuser);
         s1_word_ff      <= s1_word_in;
         s2_cmd_ff       <= s1_cmd_ff;
         s2_word_ff      <= s1_word_ff;
         s2_syn_ff       <= s2_syn_in;
         s3_cmd_ff       <= s2_cmd_ff;
         s3_word_ff      <= s2_word_ff;
         s3_syn_ff       <= s2_syn_ff;
         s3_single_ff    <= s3_single_in;
         s3_pair_ff      <= s3_pair_in;
         s4_cmd_ff       <= s3_cmd_ff;
         s4_word_ff      <= s3_word_ff;
         s4_syn_ff       <= s3_syn_ff;
         s4_single_ff    <= s4_single_in;
         s4_row_hit_ff   <= s4_row_hit_in;
         s4_row_first_ff <= s4_row_first_in;
         out_code_ff     <= out_code_in;
         out_syn_ff      <= s4_syn_ff;
         out_status_ff   <= out_status_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_status_ff, out_syn_ff, out_code_ff};

   a_no_entry_while_building: assert property (@(posedge clock) disable iff (reset)
      tbl_busy && enable |=> !s1_valid_ff)
      else $error("item entered while the syndrome table was being built");
   a_zero_syndrome_clean: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_syn_ff == '0) |-> (out_status_ff == ST_NONE))
      else $error("nonzero status with a zero syndrome");
   a_fix_needs_syndrome: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_status_ff != ST_NONE) |-> (out_syn_ff != '0))
      else $error("correction reported with a zero syndrome");

endmodule
